[hw/rtl/lmrs_pkg.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner package
// Shared item types, command format and the glyph merge helpers.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    localparam int HALF_DEPTH = 8;
    localparam int GLYPH_ROWS = 7;
    localparam int WORD_W     = 16;
    localparam int ROW_W      = 3;
    localparam int BYTE_W     = 8;

    localparam logic [WORD_W-1:0] RESET_ROW0 = 16'h0202;
    localparam logic [WORD_W-1:0] RESET_ROW1 = 16'h0404;

    typedef struct packed {
        logic              mode;
        logic              digit_select;
        logic [BYTE_W-1:0] glyph_byte_0;
        logic [BYTE_W-1:0] glyph_byte_1;
        logic [BYTE_W-1:0] glyph_byte_2;
        logic [BYTE_W-1:0] glyph_byte_3;
        logic [BYTE_W-1:0] glyph_byte_4;
        logic [BYTE_W-1:0] glyph_byte_5;
        logic [BYTE_W-1:0] glyph_byte_6;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  shown_row;
        logic [WORD_W-1:0] next_row_word;
    } t_out_item;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_BLIT = 1'b1
    } t_cmd_kind;

    // Glyph bytes are stored in row order: rows[r] belongs to row word r.
    typedef struct packed {
        t_cmd_kind                        kind;
        logic                             upper;
        logic [GLYPH_ROWS-1:0][BYTE_W-1:0] rows;
    } t_cmd;

    function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++) begin
            r[k] = b[BYTE_W-1-k];
        end
        return r;
    endfunction

    // The glyph is reversed and moved up one bit. In the lower byte the
    // ninth bit spills into bit 8 without clearing it first.
    function automatic logic [WORD_W-1:0] merge_row(
        input logic [WORD_W-1:0] word,
        input logic [BYTE_W-1:0] glyph,
        input logic              upper
    );
        logic [BYTE_W:0]   bits;
        logic [WORD_W-1:0] res;
        bits = {reverse8(glyph), 1'b0};
        if (upper) begin
            res = {bits[BYTE_W-1:0], word[BYTE_W-1:0]};
        end else begin
            res = {word[WORD_W-1:BYTE_W+1], word[BYTE_W] | bits[BYTE_W],
                   bits[BYTE_W-1:0]};
        end
        return res;
    endfunction

endpackage

[hw/rtl/lmrs_queue.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner command queue
// Two-entry queue that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
module lmrs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lmrs_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output lmrs_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    lmrs_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/lmrs_front.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner front end
// Accepts input transactions, sorts them into tick or blit commands with the
// glyph bytes put in row order, and queues them for the execution unit.
// ----------------------------------------------------------------------------
module lmrs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lmrs_pkg::t_in_item i_in_item,
    output logic               o_in_stall,
    output logic               o_cmd_valid,
    output lmrs_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);

    lmrs_pkg::t_cmd w_cmd;
    logic           w_full;

    always_comb begin
        w_cmd.kind    = i_in_item.mode ? lmrs_pkg::CMD_BLIT : lmrs_pkg::CMD_TICK;
        w_cmd.upper   = !i_in_item.digit_select;
        // The first glyph byte lands in row word 6; the last lands in row word 0.
        w_cmd.rows[0] = i_in_item.glyph_byte_6;
        w_cmd.rows[1] = i_in_item.glyph_byte_5;
        w_cmd.rows[2] = i_in_item.glyph_byte_4;
        w_cmd.rows[3] = i_in_item.glyph_byte_3;
        w_cmd.rows[4] = i_in_item.glyph_byte_2;
        w_cmd.rows[5] = i_in_item.glyph_byte_1;
        w_cmd.rows[6] = i_in_item.glyph_byte_0;
    end

    assign o_in_stall = w_full;

    lmrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .o_valid (o_cmd_valid),
        .o_cmd   (o_cmd),
        .i_pop   (i_cmd_pop)
    );

endmodule

[hw/rtl/lmrs_back.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner execution unit
// Holds the two frame halves and the scan state. A tick writes its result into
// the output register; a blit walks the eight row words, one per cycle.
// ----------------------------------------------------------------------------
module lmrs_back #(
    parameter int ROW_COUNT = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  lmrs_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    output lmrs_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    localparam int ADDR_W = $clog2(2 * lmrs_pkg::HALF_DEPTH);
    localparam int DEPTH  = 2 * lmrs_pkg::HALF_DEPTH;

    typedef enum logic {
        S_IDLE,
        S_BLIT
    } t_state;

    t_state                                          r_state;
    logic [lmrs_pkg::WORD_W-1:0]                     r_store [DEPTH];
    logic                                            r_active;
    logic                                            r_flip_pending;
    logic [lmrs_pkg::ROW_W-1:0]                      r_scan;
    logic [lmrs_pkg::ROW_W-1:0]                      r_row;
    logic                                            r_upper;
    logic [lmrs_pkg::GLYPH_ROWS-1:0][lmrs_pkg::BYTE_W-1:0] r_rows;
    logic                                            r_out_valid;
    lmrs_pkg::t_out_item                             r_out_item;

    logic                         w_out_free;
    logic                         w_take_tick;
    logic                         w_take_blit;
    logic [lmrs_pkg::ROW_W:0]     w_sum;
    logic                         w_wrap;
    logic [lmrs_pkg::ROW_W-1:0]   w_new_scan;
    logic                         w_new_active;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic [lmrs_pkg::WORD_W-1:0]  w_rd_word;
    logic                         w_glyph_row;
    logic [lmrs_pkg::WORD_W-1:0]  w_wr_word;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_take_tick = (r_state == S_IDLE) && i_cmd_valid
                         && (i_cmd.kind == lmrs_pkg::CMD_TICK) && w_out_free;
    assign w_take_blit = (r_state == S_IDLE) && i_cmd_valid
                         && (i_cmd.kind == lmrs_pkg::CMD_BLIT);
    assign o_cmd_pop   = w_take_tick || w_take_blit;

    assign w_sum        = {1'b0, r_scan} + {{lmrs_pkg::ROW_W{1'b0}}, 1'b1};
    assign w_wrap       = (w_sum >= (lmrs_pkg::ROW_W + 1)'(ROW_COUNT));
    assign w_new_scan   = w_wrap ? '0 : w_sum[lmrs_pkg::ROW_W-1:0];
    assign w_new_active = (w_wrap && r_flip_pending) ? ~r_active : r_active;

    // One read port: the blit walk uses it in S_BLIT, a tick in S_IDLE.
    assign w_rd_addr = (r_state == S_BLIT) ? {r_active, r_row}
                                           : {w_new_active, w_new_scan};
    assign w_rd_word = r_store[w_rd_addr];

    assign w_glyph_row = ({1'b0, r_row} < (lmrs_pkg::ROW_W + 1)'(lmrs_pkg::GLYPH_ROWS));
    assign w_wr_word   = w_glyph_row ? lmrs_pkg::merge_row(w_rd_word, r_rows[0], r_upper)
                                     : w_rd_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_active       <= 1'b0;
            r_flip_pending <= 1'b0;
            r_scan         <= '0;
            r_row          <= '0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                if (i == 0) begin
                    r_store[i] <= lmrs_pkg::RESET_ROW0;
                end else if (i == 1) begin
                    r_store[i] <= lmrs_pkg::RESET_ROW1;
                end else begin
                    r_store[i] <= '0;
                end
            end
        end else begin
            if (!i_out_stall && !w_take_tick) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take_tick) begin
                        r_scan                   <= w_new_scan;
                        r_active                 <= w_new_active;
                        if (w_wrap) begin
                            r_flip_pending <= 1'b0;
                        end
                        r_out_valid              <= 1'b1;
                        r_out_item.shown_row     <= r_scan;
                        r_out_item.next_row_word <= w_rd_word;
                    end else if (w_take_blit) begin
                        r_state <= S_BLIT;
                        r_row   <= '0;
                        r_upper <= i_cmd.upper;
                        r_rows  <= i_cmd.rows;
                    end
                end
                S_BLIT: begin
                    r_store[{~r_active, r_row}] <= w_wr_word;
                    r_rows <= r_rows >> lmrs_pkg::BYTE_W;
                    r_row  <= r_row + {{(lmrs_pkg::ROW_W-1){1'b0}}, 1'b1};
                    if (r_row == lmrs_pkg::ROW_W'(lmrs_pkg::HALF_DEPTH - 1)) begin
                        r_flip_pending <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_blit_sets_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLIT && r_row == lmrs_pkg::ROW_W'(lmrs_pkg::HALF_DEPTH - 1))
        |=> r_flip_pending)
        else $error("blit finished without requesting a flip");

    a_swap_needs_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != $past(r_active)) |-> ($past(r_flip_pending) && $past(w_take_tick)))
        else $error("active half changed without a pending flip");

    a_no_pop_in_blit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLIT) |-> !o_cmd_pop)
        else $error("command taken while a blit is running");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_tick |-> !(r_out_valid && i_out_stall))
        else $error("tick result would overwrite a held result");

endmodule

[hw/rtl/led_matrix_row_scanner_core.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner core
// Double-buffered row scanner for a multiplexed two-digit LED matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / i_in_item / o_in_stall) carries tick and blit
//   transactions. A tick returns one output transaction with the row shown
//   now and the active half's word for the row sent next; a blit returns none.
//   Output channel (o_out_valid / o_out_item / i_out_stall) holds its result
//   in a register until the receiver takes it.
//   A two-entry queue sits between the front end and the execution unit, so
//   input transactions are taken while a result waits on the output.
//   A tick's result passes through a queue slot and then the output register.
//   Throughput: one tick per cycle while no stall or blit holds it; a blit
//   holds the execution unit to start and then to write each row word of
//   the eight-word half in turn, limited by the single frame store read port.
//   Reset (synchronous, active low) loads the power-on frame, selects half 0,
//   clears the pending flip and the row counter, and empties the queue.
//   While the receiver stalls, the result holds, further ticks wait in the
//   queue and o_in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_core #(
    parameter int ROW_COUNT = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lmrs_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output lmrs_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    logic           w_cmd_valid;
    lmrs_pkg::t_cmd w_cmd;
    logic           w_cmd_pop;

    lmrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    lmrs_back #(
        .ROW_COUNT (ROW_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
